// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RWM_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define RWM_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define RWM_ASSERT(lbl, clk, rst, prop)
`define RWM_NEVER(lbl, clk, rst, expr)
`endif
`endif

// ===== hw/rtl/rwmmm_pkg.sv =====
package rwmmm_pkg;

  localparam int SAMPLE_W     = 24;
  localparam int COUNT_W      = 5;
  localparam int WINDOW_DEPTH = 16;
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int IDX_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SUM_W        = SAMPLE_W + $clog2(WINDOW_DEPTH);
  localparam int REM_W        = CNT_W + 1;
  localparam int DCNT_W       = $clog2(SUM_W);

  typedef enum logic [2:0] {
    ST_WAIT_IN,
    ST_PRIME,
    ST_SCAN,
    ST_DIV_INIT,
    ST_DIV,
    ST_OUT
  } step_t;

  typedef enum logic [2:0] {
    CND_NEVER,
    CND_NO_INPUT,
    CND_SCAN_MORE,
    CND_DIV_MORE,
    CND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    cond_t cond;
    step_t jmp;
    step_t nxt;
    logic  in_rdy;
    logic  ld_in;
    logic  prime;
    logic  scan;
    logic  div_init;
    logic  div_step;
    logic  out_ld;
  } uword_t;

  typedef struct packed {
    logic in_rdy;
    logic ld_in;
    logic prime;
    logic scan;
    logic div_init;
    logic div_step;
    logic out_ld;
  } ctrl_t;

  typedef struct packed {
    logic scan_more;
    logic div_more;
  } dp_stat_t;

  typedef struct packed {
    logic     in_valid;
    logic     out_busy;
    dp_stat_t dp;
  } stat_t;

  // Control store: a condition that holds jumps to jmp, otherwise the step goes to nxt.
  function automatic uword_t ucode(input step_t s);
    uword_t w;
    w      = '0;
    w.cond = CND_NEVER;
    w.jmp  = ST_WAIT_IN;
    w.nxt  = ST_WAIT_IN;
    case (s)
      ST_WAIT_IN: begin
        w.cond   = CND_NO_INPUT;
        w.jmp    = ST_WAIT_IN;
        w.nxt    = ST_PRIME;
        w.in_rdy = 1'b1;
        w.ld_in  = 1'b1;
      end
      ST_PRIME: begin
        w.nxt   = ST_SCAN;
        w.prime = 1'b1;
      end
      ST_SCAN: begin
        w.cond = CND_SCAN_MORE;
        w.jmp  = ST_SCAN;
        w.nxt  = ST_DIV_INIT;
        w.scan = 1'b1;
      end
      ST_DIV_INIT: begin
        w.nxt      = ST_DIV;
        w.div_init = 1'b1;
      end
      ST_DIV: begin
        w.cond     = CND_DIV_MORE;
        w.jmp      = ST_DIV;
        w.nxt      = ST_OUT;
        w.div_step = 1'b1;
      end
      ST_OUT: begin
        w.cond   = CND_OUT_BUSY;
        w.jmp    = ST_OUT;
        w.nxt    = ST_WAIT_IN;
        w.out_ld = 1'b1;
      end
      default: begin
        w.nxt = ST_WAIT_IN;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/rwmmm_seq.sv =====
module rwmmm_seq
  import rwmmm_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output ctrl_t ctrl
);

  step_t  step;
  step_t  step_next;
  uword_t uw;
  logic   take;

  assign uw = ucode(step);

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_WAIT_IN;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    case (uw.cond)
      CND_NEVER:     take = 1'b0;
      CND_NO_INPUT:  take = !stat.in_valid;
      CND_SCAN_MORE: take = stat.dp.scan_more;
      CND_DIV_MORE:  take = stat.dp.div_more;
      CND_OUT_BUSY:  take = stat.out_busy;
      default:       take = 1'b0;
    endcase
    step_next = take ? uw.jmp : uw.nxt;
  end

  always_comb begin
    ctrl.in_rdy   = uw.in_rdy;
    ctrl.ld_in    = uw.ld_in & stat.in_valid;
    ctrl.prime    = uw.prime;
    ctrl.scan     = uw.scan;
    ctrl.div_init = uw.div_init;
    ctrl.div_step = uw.div_step;
    ctrl.out_ld   = uw.out_ld & !stat.out_busy;
  end

endmodule

// ===== hw/rtl/rwmmm_dp.sv =====
`include "assert_macros.svh"

module rwmmm_dp
  import rwmmm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  ctrl_t               ctrl,
  input  logic [SAMPLE_W-1:0] lag_sample,
  output dp_stat_t            stat,
  output logic [SAMPLE_W-1:0] mean_q,
  output logic [SAMPLE_W-1:0] lo,
  output logic [SAMPLE_W-1:0] hi,
  output logic [CNT_W-1:0]    filled
);

  logic [SAMPLE_W-1:0] ring [WINDOW_DEPTH];
  logic [IDX_W-1:0]    wslot;
  logic [IDX_W-1:0]    k;
  logic [CNT_W-1:0]    j;
  logic [IDX_W-1:0]    raddr;
  logic [SAMPLE_W-1:0] rdata;
  logic [SUM_W-1:0]    sum;
  logic [SUM_W-1:0]    d;
  logic [REM_W-1:0]    r;
  logic [REM_W-1:0]    r_sh;
  logic [REM_W-1:0]    n_ext;
  logic                ge;
  logic [DCNT_W-1:0]   dcnt;

  always_ff @(posedge clk) begin
    if (ctrl.ld_in) begin
      ring[wslot] <= lag_sample;
    end
  end

  assign raddr = ctrl.prime ? '0 : k;

  always_ff @(posedge clk) begin
    if (ctrl.prime || ctrl.scan) begin
      rdata <= ring[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wslot  <= '0;
      filled <= '0;
      k      <= '0;
      j      <= '0;
      dcnt   <= '0;
    end else begin
      if (ctrl.ld_in) begin
        wslot <= (wslot == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : wslot + IDX_W'(1);
        if (filled < CNT_W'(WINDOW_DEPTH)) begin
          filled <= filled + CNT_W'(1);
        end
      end
      if (ctrl.prime) begin
        k <= IDX_W'(1);
        j <= '0;
      end else if (ctrl.scan) begin
        k <= k + IDX_W'(1);
        j <= j + CNT_W'(1);
      end
      if (ctrl.div_init) begin
        dcnt <= '0;
      end else if (ctrl.div_step) begin
        dcnt <= dcnt + DCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.prime) begin
      sum <= '0;
      lo  <= '1;
      hi  <= '0;
    end else if (ctrl.scan) begin
      sum <= sum + SUM_W'(rdata);
      if (rdata < lo) begin
        lo <= rdata;
      end
      if (rdata > hi) begin
        hi <= rdata;
      end
    end
  end

  // Restoring division, one quotient bit per step shifted into the dividend register.
  assign n_ext = {1'b0, filled};
  assign r_sh  = {r[REM_W-2:0], d[SUM_W-1]};
  assign ge    = (r_sh >= n_ext);

  always_ff @(posedge clk) begin
    if (ctrl.div_init) begin
      d <= sum;
      r <= '0;
    end else if (ctrl.div_step) begin
      d <= {d[SUM_W-2:0], ge};
      r <= ge ? (r_sh - n_ext) : r_sh;
    end
  end

  assign mean_q         = d[SAMPLE_W-1:0];
  assign stat.scan_more = ((j + CNT_W'(1)) != filled);
  assign stat.div_more  = (dcnt != DCNT_W'(SUM_W - 1));

  `RWM_NEVER(a_filled_in_range, clk, rst, filled > CNT_W'(WINDOW_DEPTH))
  `RWM_ASSERT(a_scan_below_count, clk, rst, ctrl.scan |-> (j < filled))
  `RWM_ASSERT(a_rem_below_count, clk, rst, ctrl.div_step |-> (r < n_ext))
  `RWM_ASSERT(a_min_le_max, clk, rst, ctrl.div_init |-> (lo <= hi))

endmodule

// ===== hw/rtl/rolling_window_min_max_mean.sv =====
// Channel  Handshake             Payload
// input    in_valid, in_ready    lag_sample
// output   out_valid, out_ready  mean_lag, min_lag, max_lag, used_count
//
// An item takes the sequencer through one accept step, a read prime, a scan step for each stored
// sample (up to 16), one setup step, 28 divider steps and one output load step, which loads
// its result into the output register.
// A new item is taken only while the sequencer waits at its first step.
// A result waiting for out_ready holds the sequencer at its output step.
// Reset clears the write slot, the fill count and the output valid flag.
`include "assert_macros.svh"

module rolling_window_min_max_mean
  import rwmmm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] lag_sample,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SAMPLE_W-1:0] mean_lag,
  output logic [SAMPLE_W-1:0] min_lag,
  output logic [SAMPLE_W-1:0] max_lag,
  output logic [COUNT_W-1:0]  used_count
);

  ctrl_t               ctrl;
  stat_t               stat;
  dp_stat_t            dp_stat;
  logic [SAMPLE_W-1:0] mean_q;
  logic [SAMPLE_W-1:0] lo;
  logic [SAMPLE_W-1:0] hi;
  logic [CNT_W-1:0]    filled;

  assign stat.in_valid = in_valid;
  assign stat.out_busy = out_valid & ~out_ready;
  assign stat.dp       = dp_stat;
  assign in_ready      = ctrl.in_rdy;

  rwmmm_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  rwmmm_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .lag_sample (lag_sample),
    .stat       (dp_stat),
    .mean_q     (mean_q),
    .lo         (lo),
    .hi         (hi),
    .filled     (filled)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_ld) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_ld) begin
      mean_lag   <= mean_q;
      min_lag    <= lo;
      max_lag    <= hi;
      used_count <= COUNT_W'(filled);
    end
  end

  `RWM_ASSERT(a_load_only_when_free, clk, rst, ctrl.out_ld |-> !(out_valid && !out_ready))
  `RWM_ASSERT(a_mean_within_range, clk, rst, ctrl.out_ld |-> (mean_q >= lo && mean_q <= hi))
  `RWM_NEVER(a_no_accept_while_busy, clk, rst, ctrl.ld_in && (ctrl.scan || ctrl.div_step))

endmodule

// ===== tb/rolling_window_min_max_mean_check.sv =====
module rolling_window_lag_checker
  import rwmmm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [SAMPLE_W-1:0] lag_sample,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [SAMPLE_W-1:0] mean_lag,
  input  logic [SAMPLE_W-1:0] min_lag,
  input  logic [SAMPLE_W-1:0] max_lag,
  input  logic [COUNT_W-1:0]  used_count,
  output int                  mismatch_count,
  output int                  awaited_count
);

  typedef struct packed {
    logic [SAMPLE_W-1:0] mean;
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] hi;
    logic [COUNT_W-1:0]  count;
  } lag_stats_t;

  logic [SAMPLE_W-1:0] lag_window [WINDOW_DEPTH];
  int unsigned         window_slot;
  int unsigned         window_fill;
  lag_stats_t          awaited_stats [$];

  initial begin
    mismatch_count = 0;
    awaited_count  = 0;
    window_slot    = 0;
    window_fill    = 0;
  end

  function automatic lag_stats_t window_stats_after(input logic [SAMPLE_W-1:0] sample);
    logic [63:0] total;
    lag_stats_t  st;
    lag_window[window_slot] = sample;
    window_slot = (window_slot + 1) % WINDOW_DEPTH;
    if (window_fill < WINDOW_DEPTH) begin
      window_fill++;
    end
    total = '0;
    st.lo = '1;
    st.hi = '0;
    for (int k = 0; k < window_fill; k++) begin
      total = total + lag_window[k];
      if (lag_window[k] > st.hi) begin
        st.hi = lag_window[k];
      end
      if (lag_window[k] < st.lo) begin
        st.lo = lag_window[k];
      end
    end
    st.mean  = SAMPLE_W'(total / window_fill);
    st.count = COUNT_W'(window_fill);
    return st;
  endfunction

  task automatic check_field(input string field, input logic [SAMPLE_W-1:0] want,
                             input logic [SAMPLE_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    lag_stats_t want;
    if (rst) begin
      window_slot = 0;
      window_fill = 0;
      awaited_stats.delete();
    end else begin
      if (in_valid && in_ready) begin
        awaited_stats.push_back(window_stats_after(lag_sample));
      end
      if (out_valid && out_ready) begin
        if (awaited_stats.size() == 0) begin
          $display("%0t: result item with none expected, got mean %0d min %0d max %0d count %0d",
                   $time, mean_lag, min_lag, max_lag, used_count);
          mismatch_count++;
        end else begin
          want = awaited_stats.pop_front();
          check_field("mean_lag", want.mean, mean_lag);
          check_field("min_lag", want.lo, min_lag);
          check_field("max_lag", want.hi, max_lag);
          check_field("used_count", SAMPLE_W'(want.count), SAMPLE_W'(used_count));
        end
      end
    end
    awaited_count <= awaited_stats.size();
  end

endmodule

// ===== tb/rolling_window_min_max_mean_test.sv =====
module rolling_window_min_max_mean_test;
  import rwmmm_pkg::*;

  localparam int DIRECTED_ITEMS = 22;
  localparam int RANDOM_ITEMS   = 1300;
  localparam int QUIET_LIMIT    = 3000;
  localparam int DRAIN_CYCLES   = 60;

  logic                clk;
  logic                rst        = 1'b1;
  logic                in_valid   = 1'b0;
  logic                in_ready;
  logic [SAMPLE_W-1:0] lag_sample = '0;
  logic                out_valid;
  logic                out_ready  = 1'b0;
  logic [SAMPLE_W-1:0] mean_lag;
  logic [SAMPLE_W-1:0] min_lag;
  logic [SAMPLE_W-1:0] max_lag;
  logic [COUNT_W-1:0]  used_count;
  logic                steady     = 1'b0;
  int                  mismatch_count;
  int                  awaited_count;
  int                  quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  rolling_window_min_max_mean u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .lag_sample (lag_sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .mean_lag   (mean_lag),
    .min_lag    (min_lag),
    .max_lag    (max_lag),
    .used_count (used_count)
  );

  rolling_window_lag_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .lag_sample     (lag_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .mean_lag       (mean_lag),
    .min_lag        (min_lag),
    .max_lag        (max_lag),
    .used_count     (used_count),
    .mismatch_count (mismatch_count),
    .awaited_count  (awaited_count)
  );

  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 15);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // The first items grow the window, then sixteen maximum samples fill it
  // completely so the sum reaches its widest value, and the last ones wrap.
  function automatic logic [SAMPLE_W-1:0] directed_lag(input int idx);
    case (idx)
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      2:       return 24'hAAAAAA;
      3:       return 24'h555555;
      20:      return 24'h000000;
      21:      return 24'h000001;
      default: return 24'hFFFFFF;
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_lag();
    case ($urandom_range(9))
      6:       return SAMPLE_W'($urandom_range(255));
      7:       return 24'hFFFFFF - SAMPLE_W'($urandom_range(255));
      8:       return $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
      9:       return SAMPLE_W'(1) << $urandom_range(SAMPLE_W - 1);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_lag(input logic [SAMPLE_W-1:0] value);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    lag_sample <= value;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int i = 0; i < DIRECTED_ITEMS; i++) begin
      send_lag(directed_lag(i));
    end
    @(negedge clk);
    in_valid <= 1'b0;
    wait (awaited_count == 0);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady = (i >= 400) && (i < 700);
      send_lag(random_lag());
    end
    @(negedge clk);
    in_valid <= 1'b0;
    steady = 1'b0;
    wait (awaited_count == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
